>>> rtl/core/assert_macros.svh
// Assertion macros used by the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clk edge outside of reset.
`define LCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a rising clk edge outside of reset.
`define LCC_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> rtl/core/lcc_pkg.sv
// Package with the types and constants of the list cross-correlation block.
package lcc_pkg;

  localparam int MAX_FIRST   = 32;
  localparam int MAX_SECOND  = 32;
  localparam int STORE_DEPTH = 32;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int LEN_W       = $clog2(MAX_FIRST + MAX_SECOND);
  localparam int SAMPLE_W    = 16;
  localparam int PROD_W      = 2 * SAMPLE_W;
  localparam int ACC_W       = 40;
  localparam int LAG_W       = 6;

  localparam logic [1:0] MODE_VALID = 2'd0;
  localparam logic [1:0] MODE_SAME  = 2'd1;
  localparam logic [1:0] MODE_FULL  = 2'd2;

  localparam logic CMD_FIRST  = 1'b0;
  localparam logic CMD_SECOND = 1'b1;

  typedef struct packed {
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } lcc_in_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] corr_value;
    logic [LAG_W-1:0]        lag_index;
    logic                    last_res;
    logic                    truncated;
  } lcc_out_t;

  // Store write request from the loader.
  typedef struct packed {
    logic                       first_en;
    logic                       second_en;
    logic [AW-1:0]              addr;
    logic signed [SAMPLE_W-1:0] data;
  } lcc_wr_t;

  // One multiply-accumulate operation as it travels down the pipeline.
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } lcc_op_t;

  typedef struct packed {
    lcc_op_t       op;
    logic [AW-1:0] first_addr;
    logic [AW-1:0] second_addr;
  } lcc_rd_t;

  typedef struct packed {
    logic busy;
    logic waiting;
  } lcc_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_POINT,
    ST_ISSUE,
    ST_WAIT,
    ST_EMIT
  } lcc_state_t;

endpackage

>>> rtl/core/lcc_store.sv
// Sample stores for both lists, one write port and registered reads.
module lcc_store (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lcc_pkg::lcc_wr_t                    wr,
  input  lcc_pkg::lcc_rd_t                    rd,
  output logic signed [lcc_pkg::SAMPLE_W-1:0] first_q,
  output logic signed [lcc_pkg::SAMPLE_W-1:0] second_q,
  output lcc_pkg::lcc_op_t                    op_q
);

  logic signed [lcc_pkg::SAMPLE_W-1:0] first_mem  [lcc_pkg::STORE_DEPTH];
  logic signed [lcc_pkg::SAMPLE_W-1:0] second_mem [lcc_pkg::STORE_DEPTH];
  logic signed [lcc_pkg::SAMPLE_W-1:0] first_q_r;
  logic signed [lcc_pkg::SAMPLE_W-1:0] second_q_r;
  lcc_pkg::lcc_op_t                    op_r;

  always_ff @(posedge clk) begin
    if (wr.first_en) begin
      first_mem[wr.addr] <= wr.data;
    end
    first_q_r <= first_mem[rd.first_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.second_en) begin
      second_mem[wr.addr] <= wr.data;
    end
    second_q_r <= second_mem[rd.second_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= '0;
    end else begin
      op_r <= rd.op;
    end
  end

  assign first_q  = first_q_r;
  assign second_q = second_q_r;
  assign op_q     = op_r;

endmodule

>>> rtl/core/lcc_mac.sv
// Shared multiply-accumulate unit: product register, then 40-bit accumulator.
module lcc_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [lcc_pkg::SAMPLE_W-1:0] a,
  input  logic signed [lcc_pkg::SAMPLE_W-1:0] b,
  input  lcc_pkg::lcc_op_t                    op,
  output logic signed [lcc_pkg::ACC_W-1:0]    acc,
  output logic                                done
);

  logic signed [lcc_pkg::PROD_W-1:0] prod_r;
  lcc_pkg::lcc_op_t                  op1_r;
  logic signed [lcc_pkg::ACC_W-1:0]  acc_r;
  logic signed [lcc_pkg::ACC_W-1:0]  acc_nxt;
  logic signed [lcc_pkg::ACC_W-1:0]  prod_ext;
  logic                              done_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  assign prod_ext = lcc_pkg::ACC_W'(prod_r);

  always_comb begin
    acc_nxt = acc_r;
    if (op1_r.vld) begin
      acc_nxt = op1_r.first ? prod_ext : acc_r + prod_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op1_r  <= '0;
      acc_r  <= '0;
      done_r <= 1'b0;
    end else begin
      op1_r  <= op;
      acc_r  <= acc_nxt;
      done_r <= op1_r.vld && op1_r.last;
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

>>> rtl/core/lcc_seq.sv
// Loader and sequencer: list bookkeeping, slice setup and MAC issue control.
module lcc_seq (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  lcc_pkg::lcc_in_t                 in_data,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_data,
  input  logic signed [lcc_pkg::ACC_W-1:0] acc,
  input  logic                             mac_done,
  input  logic                             out_free,
  output lcc_pkg::lcc_wr_t                 wr,
  output lcc_pkg::lcc_rd_t                 rd,
  output logic                             emit_vld,
  output lcc_pkg::lcc_out_t                emit_data,
  output lcc_pkg::lcc_stat_t               stat
);

  localparam int AW    = lcc_pkg::AW;
  localparam int CNT_W = lcc_pkg::CNT_W;
  localparam int LEN_W = lcc_pkg::LEN_W;

  lcc_pkg::lcc_state_t state_r, state_nxt;
  logic [1:0]       mode_r;
  logic [CNT_W-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic             open_a_r, open_a_nxt, open_b_r, open_b_nxt;
  logic             drop_a_r, drop_a_nxt, drop_b_r, drop_b_nxt;
  logic [LEN_W-1:0] k_r, k_nxt, p_r, p_nxt, len_r, len_nxt;
  logic [AW-1:0]    i_r, i_nxt, b_r, b_nxt, imax_r, imax_nxt;
  logic             first_r, first_nxt;

  logic             accept;
  logic             start;
  logic             cur_open;
  logic [CNT_W-1:0] cur_cnt, base_cnt;
  logic             room;
  logic [LEN_W-1:0] na, nb, mn, mx;
  logic [LEN_W-1:0] off, len;
  logic [LEN_W-1:0] imin, imax, b0;
  logic             issue_last;
  logic             last_point;

  assign accept   = in_valid && (state_r == lcc_pkg::ST_IDLE);
  assign cur_open = (in_data.cmd == lcc_pkg::CMD_SECOND) ? open_b_r : open_a_r;
  assign cur_cnt  = (in_data.cmd == lcc_pkg::CMD_SECOND) ? cnt_b_r : cnt_a_r;
  assign base_cnt = cur_open ? '0 : cur_cnt;
  assign room     = (in_data.cmd == lcc_pkg::CMD_SECOND) ?
                    (base_cnt < CNT_W'(lcc_pkg::MAX_SECOND)) :
                    (base_cnt < CNT_W'(lcc_pkg::MAX_FIRST));
  // A closing element of the first list computes, provided the second list has data.
  assign start    = accept && (in_data.cmd == lcc_pkg::CMD_FIRST) && in_data.last &&
                    (cnt_b_r != '0);

  assign na = LEN_W'(cnt_a_r);
  assign nb = LEN_W'(cnt_b_r);
  assign mn = (na < nb) ? na : nb;
  assign mx = (na < nb) ? nb : na;

  always_comb begin
    unique case (mode_r)
      lcc_pkg::MODE_VALID: begin
        off = mn - LEN_W'(1);
        len = mx - mn + LEN_W'(1);
      end
      lcc_pkg::MODE_SAME: begin
        off = (mn - LEN_W'(1)) >> 1;
        len = mx;
      end
      default: begin
        off = '0;
        len = na + nb - LEN_W'(1);
      end
    endcase
  end

  // Range of first-list indexes that overlap the second list at lag k.
  always_comb begin
    if (k_r >= nb) begin
      imin = k_r - nb + LEN_W'(1);
      b0   = '0;
    end else begin
      imin = '0;
      b0   = nb - LEN_W'(1) - k_r;
    end
    imax = (k_r < na) ? k_r : na - LEN_W'(1);
  end

  assign issue_last = (i_r == imax_r);
  assign last_point = (p_r == len_r - LEN_W'(1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lcc_pkg::ST_IDLE:  if (start) state_nxt = lcc_pkg::ST_SETUP;
      lcc_pkg::ST_SETUP: state_nxt = lcc_pkg::ST_POINT;
      lcc_pkg::ST_POINT: state_nxt = lcc_pkg::ST_ISSUE;
      lcc_pkg::ST_ISSUE: if (issue_last) state_nxt = lcc_pkg::ST_WAIT;
      lcc_pkg::ST_WAIT:  if (mac_done) state_nxt = lcc_pkg::ST_EMIT;
      lcc_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = last_point ? lcc_pkg::ST_IDLE : lcc_pkg::ST_POINT;
        end
      end
      default: state_nxt = lcc_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath registers.
  always_comb begin
    cnt_a_nxt  = cnt_a_r;
    cnt_b_nxt  = cnt_b_r;
    open_a_nxt = open_a_r;
    open_b_nxt = open_b_r;
    drop_a_nxt = drop_a_r;
    drop_b_nxt = drop_b_r;
    k_nxt      = k_r;
    p_nxt      = p_r;
    len_nxt    = len_r;
    i_nxt      = i_r;
    b_nxt      = b_r;
    imax_nxt   = imax_r;
    first_nxt  = first_r;
    wr         = '0;
    rd         = '0;
    emit_vld   = 1'b0;

    wr.addr = base_cnt[AW-1:0];
    wr.data = in_data.sample;
    rd.first_addr  = i_r;
    rd.second_addr = b_r;

    unique case (state_r)
      lcc_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_data.cmd == lcc_pkg::CMD_SECOND) begin
            wr.second_en = room;
            cnt_b_nxt    = room ? base_cnt + CNT_W'(1) : base_cnt;
            drop_b_nxt   = (open_b_r ? 1'b0 : drop_b_r) || !room;
            open_b_nxt   = in_data.last;
          end else begin
            wr.first_en = room;
            cnt_a_nxt   = room ? base_cnt + CNT_W'(1) : base_cnt;
            drop_a_nxt  = (open_a_r ? 1'b0 : drop_a_r) || !room;
            open_a_nxt  = in_data.last;
          end
        end
      end
      lcc_pkg::ST_SETUP: begin
        k_nxt   = off;
        p_nxt   = '0;
        len_nxt = len;
      end
      lcc_pkg::ST_POINT: begin
        i_nxt     = imin[AW-1:0];
        b_nxt     = b0[AW-1:0];
        imax_nxt  = imax[AW-1:0];
        first_nxt = 1'b1;
      end
      lcc_pkg::ST_ISSUE: begin
        rd.op.vld  = 1'b1;
        rd.op.first = first_r;
        rd.op.last = issue_last;
        i_nxt      = i_r + AW'(1);
        b_nxt      = b_r + AW'(1);
        first_nxt  = 1'b0;
      end
      lcc_pkg::ST_WAIT: begin
      end
      lcc_pkg::ST_EMIT: begin
        emit_vld = 1'b1;
        if (out_free) begin
          p_nxt = p_r + LEN_W'(1);
          k_nxt = k_r + LEN_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= lcc_pkg::ST_IDLE;
      mode_r   <= lcc_pkg::MODE_VALID;
      cnt_a_r  <= '0;
      cnt_b_r  <= '0;
      open_a_r <= 1'b1;
      open_b_r <= 1'b1;
      drop_a_r <= 1'b0;
      drop_b_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      if (cfg_we) begin
        mode_r <= cfg_data;
      end
      cnt_a_r  <= cnt_a_nxt;
      cnt_b_r  <= cnt_b_nxt;
      open_a_r <= open_a_nxt;
      open_b_r <= open_b_nxt;
      drop_a_r <= drop_a_nxt;
      drop_b_r <= drop_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    p_r     <= p_nxt;
    len_r   <= len_nxt;
    i_r     <= i_nxt;
    b_r     <= b_nxt;
    imax_r  <= imax_nxt;
    first_r <= first_nxt;
  end

  assign emit_data.corr_value = acc;
  assign emit_data.lag_index  = lcc_pkg::LAG_W'(p_r);
  assign emit_data.last_res   = last_point;
  assign emit_data.truncated  = drop_a_r || drop_b_r;

  assign stat.busy    = (state_r != lcc_pkg::ST_IDLE);
  assign stat.waiting = (state_r == lcc_pkg::ST_WAIT);

endmodule

>>> rtl/core/list_cross_correlation.sv
// Top level of the list cross-correlation block with its output register.
//
// Usage: requests on the in_ channel carry one list element each. cmd selects
// the second list (1) or the first list (0); last closes the list, and the
// next element of that list starts a new one. Up to 32 elements per list are
// kept; later ones are dropped and reported through the truncated field.
// A closing element of the first list starts the computation, if the second
// list holds any data, and the block then emits one out_ request per point of
// the slice that cfg_data selects (0 valid, 1 same, 2 and 3 full).
// Loading accepts one element per cycle while the block is idle. A computation
// sets up the slice and then, for each point, issues the overlapping terms to
// the single multiply-accumulate unit, waits for the sum and emits it; in_stall
// stays high for the whole computation.
// Results pass through an output register; while out_stall is high the
// current result holds and the sequencer waits. Reset clears the list counts,
// the drop flags and the mode; stored samples are not cleared. A write to
// cfg_data lands at any edge, and the mode is read once as a computation sets up.
`include "assert_macros.svh"

module list_cross_correlation (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lcc_pkg::lcc_in_t     in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lcc_pkg::lcc_out_t    out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_data
);

  lcc_pkg::lcc_wr_t                    wr;
  lcc_pkg::lcc_rd_t                    rd;
  lcc_pkg::lcc_op_t                    op_q;
  lcc_pkg::lcc_stat_t                  stat;
  lcc_pkg::lcc_out_t                   emit_data;
  logic signed [lcc_pkg::SAMPLE_W-1:0] first_q;
  logic signed [lcc_pkg::SAMPLE_W-1:0] second_q;
  logic signed [lcc_pkg::ACC_W-1:0]    acc;
  logic                                mac_done;
  logic                                emit_vld;
  logic                                out_free;
  logic                                emit_fire;
  logic                                out_valid_r;
  lcc_pkg::lcc_out_t                   out_data_r;

  lcc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .acc       (acc),
    .mac_done  (mac_done),
    .out_free  (out_free),
    .wr        (wr),
    .rd        (rd),
    .emit_vld  (emit_vld),
    .emit_data (emit_data),
    .stat      (stat)
  );

  lcc_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .rd       (rd),
    .first_q  (first_q),
    .second_q (second_q),
    .op_q     (op_q)
  );

  lcc_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .a     (first_q),
    .b     (second_q),
    .op    (op_q),
    .acc   (acc),
    .done  (mac_done)
  );

  assign in_stall  = stat.busy;
  assign out_free  = !out_valid_r || !out_stall;
  assign emit_fire = emit_vld && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_data_r <= emit_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A finished sum only comes back while the sequencer waits for it.
  `LCC_ASSERT(a_done_in_wait, mac_done |-> stat.waiting, "MAC result outside wait state")
  // The completion pulse lasts one cycle, since a point issues one chain of terms.
  `LCC_ASSERT(a_done_pulse, mac_done |=> !mac_done, "MAC completion longer than one cycle")
  // After the final point of a slice the block takes requests again.
  `LCC_ASSERT(a_idle_after_last, (emit_fire && emit_data.last_res) |=> !in_stall,
              "block still busy after final point")

endmodule

>>> verif/tb.sv
// Self-checking testbench for the list cross-correlation block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lcc_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;
  localparam int IDLE_WAIT   = 40;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 50;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic signed [SAMPLE_W-1:0] Q15_MIN = 16'h8000;
  localparam logic signed [SAMPLE_W-1:0] Q15_MAX = 16'h7fff;

  // Tracks both lists as the block sees them and holds the points owed by it.
  class corr_checker;
    logic signed [SAMPLE_W-1:0] store [2][STORE_DEPTH];
    int unsigned count [2];
    bit          open_list [2];
    bit          dropped [2];
    logic [1:0]  mode;
    lcc_out_t    expected_points [$];
    int          mismatches;

    function new();
      for (int l = 0; l < 2; l++) begin
        count[l] = 0;
        open_list[l] = 1'b1;
        dropped[l] = 1'b0;
      end
      mode = MODE_VALID;
      mismatches = 0;
    endfunction

    function void set_mode(logic [1:0] m);
      mode = m;
    endfunction

    function void note_request(lcc_in_t req);
      int unsigned l;
      int unsigned cap;
      l = int'(req.cmd);
      cap = (req.cmd == CMD_SECOND) ? MAX_SECOND : MAX_FIRST;
      if (open_list[l]) begin
        count[l] = 0;
        dropped[l] = 1'b0;
        open_list[l] = 1'b0;
      end
      if (count[l] < cap && count[l] < STORE_DEPTH) begin
        store[l][count[l]] = req.sample;
        count[l]++;
      end else begin
        dropped[l] = 1'b1;
      end
      if (req.last)
        open_list[l] = 1'b1;
      if (req.cmd == CMD_FIRST && req.last)
        predict_slice();
    endfunction

    function void predict_slice();
      int unsigned na, nb, mn, mx, off, len, k;
      longint acc;
      lcc_out_t pt;
      na = count[CMD_FIRST];
      nb = count[CMD_SECOND];
      if (na == 0 || nb == 0)
        return;
      mn = (na < nb) ? na : nb;
      mx = (na < nb) ? nb : na;
      case (mode)
        MODE_VALID: begin
          off = mn - 1;
          len = mx - mn + 1;
        end
        MODE_SAME: begin
          off = (mn - 1) / 2;
          len = mx;
        end
        default: begin
          off = 0;
          len = na + nb - 1;
        end
      endcase
      for (int unsigned p = 0; p < len; p++) begin
        k = off + p;
        acc = 0;
        for (int unsigned i = 0; i < na; i++) begin
          if (k >= i && k - i < nb)
            acc += longint'(store[CMD_FIRST][i]) *
                   longint'(store[CMD_SECOND][nb - 1 - (k - i)]);
        end
        pt.corr_value = acc[ACC_W-1:0];
        pt.lag_index  = p[LAG_W-1:0];
        pt.last_res   = (p + 1 == len);
        pt.truncated  = dropped[CMD_FIRST] || dropped[CMD_SECOND];
        expected_points = {expected_points, pt};
      end
    endfunction

    function void compare_field(string name, logic signed [63:0] want,
                                logic signed [63:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_point(lcc_out_t got);
      lcc_out_t want;
      if (expected_points.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected: corr_value %0d lag_index %0d",
                 $time, got.corr_value, got.lag_index);
        return;
      end
      want = expected_points.pop_front();
      compare_field("corr_value", want.corr_value, got.corr_value);
      compare_field("lag_index", want.lag_index, got.lag_index);
      compare_field("last_res", want.last_res, got.last_res);
      compare_field("truncated", want.truncated, got.truncated);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  lcc_in_t    in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  lcc_out_t   out_data;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_data = MODE_VALID;

  corr_checker sb = new();
  bit          calm = 1'b0;
  int          items_sent = 0;
  int          cycles = 0;
  int          stall_left = 0;
  int          free_left = 0;

  list_cross_correlation dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (calm)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    else if (r < 85)
      return $urandom_range(1, 3);
    else if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10)
      return Q15_MIN;
    else if (r < 20)
      return Q15_MAX;
    else if (r < 35)
      return 16'(int'($urandom_range(0, 8)) - 4);
    return 16'($urandom);
  endfunction

  // Most lists are short; a few run past the store depth.
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85)
      return $urandom_range(1, 8);
    else if (r < 95)
      return $urandom_range(9, 29);
    return $urandom_range(30, 35);
  endfunction

  task automatic send_element(input logic cmd, input logic signed [SAMPLE_W-1:0] s,
                              input logic last);
    lcc_in_t req;
    int gap;
    req.cmd = cmd;
    req.sample = s;
    req.last = last;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    sb.note_request(req);
    items_sent++;
  endtask

  task automatic send_list(input logic cmd, input int n, input logic close);
    for (int i = 0; i < n; i++)
      send_element(cmd, pick_sample(), close && (i == n - 1));
  endtask

  task automatic set_mode(input logic [1:0] m);
    in_valid <= 1'b0;
    while (sb.expected_points.size() != 0) @(posedge clk);
    // A closing request with no second list leaves no result to wait for.
    repeat (IDLE_WAIT) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_mode(m);
  endtask

  task automatic run_sequence();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      if ($urandom_range(0, 9) < 7)
        send_list(CMD_SECOND, pick_len(), 1'b1);
      send_list(CMD_FIRST, pick_len(), 1'b1);
    end else if (r < 82) begin
      // The first list closes while the second is still being loaded.
      send_list(CMD_SECOND, $urandom_range(1, 5), 1'b0);
      send_list(CMD_FIRST, pick_len(), 1'b1);
      if ($urandom_range(0, 1))
        send_list(CMD_SECOND, $urandom_range(1, 3), 1'b1);
    end else if (r < 92) begin
      n = $urandom_range(2, 8);
      for (int i = 0; i < n; i++)
        send_element(logic'($urandom_range(0, 1)), pick_sample(),
                     $urandom_range(0, 9) == 0);
      send_element(CMD_FIRST, pick_sample(), 1'b1);
    end else begin
      send_list(CMD_FIRST, $urandom_range(1, 4), 1'b0);
      send_list(CMD_SECOND, $urandom_range(1, 6), 1'b1);
      send_list(CMD_FIRST, $urandom_range(1, 4), 1'b1);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_point(out_data);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (free_left > 0) begin
        free_left--;
      end else begin
        stall_left = pick_gap();
        free_left = $urandom_range(0, 8);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time,
               sb.expected_points.size());
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    int target;
    logic [1:0] phase_mode;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // A closing request before any second list has been loaded yields nothing.
    send_element(CMD_FIRST, Q15_MIN, 1'b1);
    send_element(CMD_SECOND, Q15_MAX, 1'b0);
    send_element(CMD_SECOND, Q15_MIN, 1'b1);
    send_element(CMD_FIRST, Q15_MIN, 1'b0);
    send_element(CMD_FIRST, Q15_MIN, 1'b0);
    send_element(CMD_FIRST, Q15_MAX, 1'b1);
    // Second list left open when the first one closes.
    send_element(CMD_SECOND, 16'sd1, 1'b0);
    send_element(CMD_FIRST, Q15_MAX, 1'b1);
    send_element(CMD_SECOND, -16'sd1, 1'b1);
    send_element(CMD_FIRST, 16'sd100, 1'b0);
    send_element(CMD_FIRST, -16'sd200, 1'b0);
    send_element(CMD_FIRST, 16'sd300, 1'b1);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: phase_mode = MODE_SAME;
        1: phase_mode = MODE_FULL;
        2: phase_mode = MODE_SPARE;
        3: phase_mode = MODE_VALID;
        default: phase_mode = 2'($urandom_range(0, 3));
      endcase
      set_mode(phase_mode);
      calm = ($urandom_range(0, 3) == 0);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target)
        run_sequence();
    end

    calm = 1'b0;
    in_valid <= 1'b0;
    while (sb.expected_points.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT + 20) @(posedge clk);
    if (sb.mismatches == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
